FILE: rtl/core/bpc_pkg.sv
package bpc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 5;

    localparam logic [ADDR_W-1:0] REG_AC1_AC2 = 5'd0;
    localparam logic [ADDR_W-1:0] REG_AC3_AC4 = 5'd4;
    localparam logic [ADDR_W-1:0] REG_AC5_AC6 = 5'd8;
    localparam logic [ADDR_W-1:0] REG_B1_B2   = 5'd12;
    localparam logic [ADDR_W-1:0] REG_MC_MD   = 5'd16;
    localparam logic [ADDR_W-1:0] REG_OSS     = 5'd20;

    localparam logic [1:0] OSS_RESET = 2'd2;

    localparam logic signed [31:0] C_B6_OFFSET = 32'sd4000;
    localparam logic [31:0]        C_B4_OFFSET = 32'd32768;
    localparam logic [15:0]        C_B7_SCALE  = 16'd50000;
    localparam logic signed [31:0] C_P_K1      = 32'sd3038;
    localparam logic signed [31:0] C_P_K2      = -32'sd7357;
    localparam logic signed [31:0] C_P_K3      = 32'sd3791;
    localparam logic [31:0]        C_B7_BIG    = 32'h8000_0000;

    localparam logic signed [31:0] T_MIN = -32'sd1024;
    localparam logic signed [31:0] T_MAX = 32'sd1023;
    localparam logic signed [31:0] P_MAX = 32'sd131071;

    typedef logic signed [10:0] t_temp;
    typedef logic [16:0]        t_press;

endpackage

FILE: rtl/core/bpc_if.sv
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic        valid;
    logic        ready;
    logic signed [10:0] temperature;
    logic [16:0] pressure;
    logic        divide_fault;
    modport source (output valid, temperature, pressure, divide_fault, input ready);
    modport sink (input valid, temperature, pressure, divide_fault, output ready);
endinterface

FILE: rtl/core/barometer_pressure_compensation.sv
// channel | dir | handshake     | payload
// i_in    | in  | valid/ready   | raw_temperature[15:0], raw_pressure[23:0]
// o_res   | out | valid/ready   | temperature[10:0] s, pressure[16:0], divide_fault
// apb     | in  | psel/penable  | coefficient and oversampling registers
// One item per cycle while the output is not stalled; the two dividers are 32-stage pipelines.
// Whole pipeline advances together; a stalled output freezes every stage.
// Synchronous active-low reset clears valid bits and the coefficient registers, and sets oversampling to 2.
module barometer_pressure_compensation
    import bpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpc_in_if.sink            i_in,
    bpc_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [31:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    logic [1:0]  r_oss;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac12 <= '0;
            r_ac34 <= '0;
            r_ac56 <= '0;
            r_b12  <= '0;
            r_mcmd <= '0;
            r_oss  <= OSS_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_AC1_AC2: r_ac12 <= pwdata;
                REG_AC3_AC4: r_ac34 <= pwdata;
                REG_AC5_AC6: r_ac56 <= pwdata;
                REG_B1_B2:   r_b12  <= pwdata;
                REG_MC_MD:   r_mcmd <= pwdata;
                REG_OSS:     r_oss  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_AC1_AC2: prdata = r_ac12;
            REG_AC3_AC4: prdata = r_ac34;
            REG_AC5_AC6: prdata = r_ac56;
            REG_B1_B2:   prdata = r_b12;
            REG_MC_MD:   prdata = r_mcmd;
            REG_OSS:     prdata = {30'd0, r_oss};
            default:     prdata = '0;
        endcase
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0] ac4, ac5, ac6;
    assign ac1 = 32'(signed'(r_ac12[31:16]));
    assign ac2 = 32'(signed'(r_ac12[15:0]));
    assign ac3 = 32'(signed'(r_ac34[31:16]));
    assign ac4 = r_ac34[15:0];
    assign ac5 = r_ac56[31:16];
    assign ac6 = r_ac56[15:0];
    assign b1  = 32'(signed'(r_b12[31:16]));
    assign b2  = 32'(signed'(r_b12[15:0]));
    assign mc  = 32'(signed'(r_mcmd[31:16]));
    assign md  = 32'(signed'(r_mcmd[15:0]));

    logic w_adv;
    assign w_adv      = !o_res.valid || o_res.ready;
    assign i_in.ready = w_adv;

    // stage 1: x1 and up
    logic               r_v1;
    logic signed [31:0] r1_x1;
    logic [23:0]        r1_up;
    logic signed [63:0] w1_prod;
    assign w1_prod = ($signed({16'd0, i_in.raw_temperature}) - $signed({16'd0, ac6}))
                     * $signed({16'd0, ac5});

    // stage 2: divider operands
    logic               r_v2;
    logic signed [31:0] r2_x1;
    logic [23:0]        r2_up;
    logic               r2_neg, r2_f;
    logic [31:0]        r2_num, r2_den;
    logic signed [31:0] w2_num, w2_den;
    assign w2_num = mc <<< 11;
    assign w2_den = r1_x1 + md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x1  <= $signed(w1_prod[31:0]) >>> 15;
            r1_up  <= i_in.raw_pressure >> (4'd8 - {2'd0, r_oss});
            r2_x1  <= r1_x1;
            r2_up  <= r1_up;
            r2_neg <= w2_num[31] ^ w2_den[31];
            r2_f   <= (w2_den == 0);
            r2_num <= w2_num[31] ? 32'(-w2_num) : w2_num;
            r2_den <= w2_den[31] ? 32'(-w2_den) : w2_den;
        end
    end

    logic        d1_v;
    logic [31:0] d1_q;
    logic [57:0] d1_s;

    bpc_div #(.W(32), .SW(58)) u_div_t (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_v2),
        .i_dividend (r2_num),
        .i_divisor  (r2_den),
        .i_side     ({r2_x1, r2_up, r2_neg, r2_f}),
        .o_valid    (d1_v),
        .o_quotient (d1_q),
        .o_side     (d1_s)
    );

    // stage 3: b5, t, b6
    logic signed [31:0] w3_x1, w3_x2, w3_b5, w3_t;
    logic [23:0]        w3_up;
    assign w3_x1 = $signed(d1_s[57:26]);
    assign w3_up = d1_s[25:2];
    assign w3_x2 = d1_s[1] ? 32'(-$signed(d1_q)) : $signed(d1_q);
    assign w3_b5 = w3_x1 + w3_x2;
    assign w3_t  = (w3_b5 + 32'sd8) >>> 4;

    logic               r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic signed [31:0] r3_b6;
    t_temp              r3_t, r4_t, r5_t, r6_t, r7_t, r8_t;
    logic               r3_f, r4_f, r5_f, r6_f, r7_f, r8_f;
    logic [23:0]        r3_up, r4_up, r5_up;
    logic signed [31:0] r4_sq, r4_x2, r4_x1c;
    logic signed [31:0] r5_x1, r5_x2, r5_x1c, r5_x2d;
    logic signed [31:0] r6_b3, r6_x3;
    logic [23:0]        r6_up;
    logic [31:0]        r7_b4, r7_b7;
    logic [31:0]        r8_dvd, r8_b4;
    logic               r8_big;

    logic signed [63:0] w4_sq, w4_x2, w4_x1c, w5_x1, w5_x2;
    assign w4_sq  = r3_b6 * r3_b6;
    assign w4_x2  = ac2 * r3_b6;
    assign w4_x1c = ac3 * r3_b6;
    assign w5_x1  = b2 * r4_sq;
    assign w5_x2  = b1 * r4_sq;

    logic signed [31:0] w6_x3, w6_a, w6_x3p;
    assign w6_x3  = r5_x1 + r5_x2;
    assign w6_a   = ((((ac1 <<< 2) + w6_x3) <<< r_oss) + 32'sd2) >>> 2;
    assign w6_x3p = (r5_x1c + r5_x2d + 32'sd2) >>> 2;

    logic [47:0] w7_b4p, w7_b7p;
    assign w7_b4p = ac4 * (r6_x3 + C_B4_OFFSET);
    assign w7_b7p = (r6_up - r6_b3) * (C_B7_SCALE >> r_oss);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= d1_v;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_b6  <= w3_b5 - C_B6_OFFSET;
            r3_t   <= (w3_t < T_MIN) ? t_temp'(T_MIN) :
                      (w3_t > T_MAX) ? t_temp'(T_MAX) : w3_t[10:0];
            r3_f   <= d1_s[0];
            r3_up  <= w3_up;
            r4_sq  <= $signed(w4_sq[31:0]) >>> 12;
            r4_x2  <= $signed(w4_x2[31:0]) >>> 11;
            r4_x1c <= $signed(w4_x1c[31:0]) >>> 13;
            r4_t   <= r3_t;
            r4_f   <= r3_f;
            r4_up  <= r3_up;
            r5_x1  <= $signed(w5_x1[31:0]) >>> 11;
            r5_x2d <= $signed(w5_x2[31:0]) >>> 16;
            r5_x2  <= r4_x2;
            r5_x1c <= r4_x1c;
            r5_t   <= r4_t;
            r5_f   <= r4_f;
            r5_up  <= r4_up;
            r6_b3  <= w6_a;
            r6_x3  <= w6_x3p;
            r6_up  <= r5_up;
            r6_t   <= r5_t;
            r6_f   <= r5_f;
            r7_b4  <= {15'd0, w7_b4p[31:15]};
            r7_b7  <= w7_b7p[31:0];
            r7_t   <= r6_t;
            r7_f   <= r6_f;
            r8_big <= (r7_b7 >= C_B7_BIG);
            r8_dvd <= (r7_b7 >= C_B7_BIG) ? r7_b7 : {r7_b7[30:0], 1'b0};
            r8_b4  <= r7_b4;
            r8_t   <= r7_t;
            r8_f   <= r7_f || (r7_b4 == 0);
        end
    end

    logic        d2_v;
    logic [31:0] d2_q;
    logic [12:0] d2_s;

    bpc_div #(.W(32), .SW(13)) u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_v8),
        .i_dividend (r8_dvd),
        .i_divisor  (r8_b4),
        .i_side     ({r8_t, r8_f, r8_big}),
        .o_valid    (d2_v),
        .o_quotient (d2_q),
        .o_side     (d2_s)
    );

    logic signed [31:0] w9_p, w9_ps;
    logic signed [63:0] w9_sq, w9_x2;
    assign w9_p  = d2_s[0] ? $signed({d2_q[30:0], 1'b0}) : $signed(d2_q);
    assign w9_ps = w9_p >>> 8;
    assign w9_sq = w9_ps * w9_ps;
    assign w9_x2 = C_P_K2 * w9_p;

    logic               r_v9, r_v10;
    logic signed [31:0] r9_p, r9_x1, r9_x2, r10_p, r10_x1, r10_x2;
    t_temp              r9_t, r10_t;
    logic               r9_f, r10_f;
    logic signed [63:0] w10_x1;
    assign w10_x1 = r9_x1 * C_P_K1;

    logic signed [31:0] w11_p;
    assign w11_p = r10_p + ((r10_x1 + r10_x2 + C_P_K3) >>> 4);

    logic   r_ov;
    t_temp  r_ot;
    t_press r_op;
    logic   r_of;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_v9  <= d2_v;
            r_v10 <= r_v9;
            r_ov  <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_p   <= w9_p;
            r9_x1  <= $signed(w9_sq[31:0]);
            r9_x2  <= $signed(w9_x2[31:0]) >>> 16;
            r9_t   <= d2_s[12:2];
            r9_f   <= d2_s[1];
            r10_p  <= r9_p;
            r10_x1 <= $signed(w10_x1[31:0]) >>> 16;
            r10_x2 <= r9_x2;
            r10_t  <= r9_t;
            r10_f  <= r9_f;
            r_of   <= r10_f;
            r_ot   <= r10_f ? '0 : r10_t;
            r_op   <= r10_f ? '0 :
                      (w11_p < 0) ? '0 :
                      (w11_p > P_MAX) ? t_press'(P_MAX) : w11_p[16:0];
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.temperature  = r_ot;
    assign o_res.pressure     = r_op;
    assign o_res.divide_fault = r_of;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.divide_fault |-> o_res.temperature == 0 && o_res.pressure == 0)
        else $error("fault result not zero");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_res.valid || o_res.ready))
        else $error("ready does not follow output stall");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_v8) && $stable(r_v3) && $stable(r_v10))
        else $error("pipeline moved during stall");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid && !r_v1)
        else $error("valid after reset");

endmodule

FILE: rtl/core/bpc_div.sv
module bpc_div #(
    parameter int unsigned W  = 32,
    parameter int unsigned SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_dividend,
    input  logic [W-1:0]  i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quotient,
    output logic [SW-1:0] o_side
);

    logic [W-1:0]  r_rem  [W];
    logic [W-1:0]  r_dvd  [W];
    logic [W-1:0]  r_dvs  [W];
    logic [W-1:0]  r_quo  [W];
    logic [SW-1:0] r_side [W];
    logic [W-1:0]  r_vld;

    logic [W-1:0]  n_rem  [W];
    logic [W-1:0]  n_dvd  [W];
    logic [W-1:0]  n_quo  [W];

    always_comb begin
        for (int k = 0; k < W; k++) begin
            logic [W-1:0] rem_in;
            logic [W-1:0] dvd_in;
            logic [W-1:0] dvs_in;
            logic [W-1:0] quo_in;
            logic [W:0]   trial;
            rem_in = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k-1];
            dvd_in = (k == 0) ? i_dividend : r_dvd[(k == 0) ? 0 : k-1];
            dvs_in = (k == 0) ? i_divisor : r_dvs[(k == 0) ? 0 : k-1];
            quo_in = (k == 0) ? '0 : r_quo[(k == 0) ? 0 : k-1];
            trial  = {rem_in, dvd_in[W-1]};
            if (trial >= {1'b0, dvs_in}) begin
                n_rem[k] = W'(trial - {1'b0, dvs_in});
                n_quo[k] = {quo_in[W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[W-1:0];
                n_quo[k] = {quo_in[W-2:0], 1'b0};
            end
            n_dvd[k] = {dvd_in[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k] <= n_rem[k];
                r_dvd[k] <= n_dvd[k];
                r_quo[k] <= n_quo[k];
                r_dvs[k] <= (k == 0) ? i_divisor : r_dvs[(k == 0) ? 0 : k-1];
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_valid    = r_vld[W-1];
    assign o_quotient = r_quo[W-1];
    assign o_side     = r_side[W-1];

endmodule
